// File: hw/rtl/lmbs_pkg.sv
package lmbs_pkg;

	// fixed field widths
	localparam int BYTE_W     = 8;
	localparam int LEVEL_W    = 10;
	localparam int PLANE_W    = 4;
	localparam int ROW_ADDR_W = 5;
	localparam int CFG_W      = 7;
	localparam int HALF_W     = CFG_W - 1;
	localparam int GAMMA_DEPTH = 256;
	localparam int NUM_CH     = 3;
	localparam int MAX_PLANES = 10;

	// register reset values
	localparam logic [PLANE_W-1:0] PLANES_RST = 4'd10;
	localparam logic [CFG_W-1:0]   WIDTH_RST  = 7'd64;
	localparam logic [CFG_W-1:0]   HEIGHT_RST = 7'd32;

	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_GAMMA = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_e_t;

	typedef enum logic [1:0] {
		REG_PLANES = 2'd0,
		REG_BUFFER = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_e_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_e_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_TOP  = 2'd1,
		ST_BOT  = 2'd2,
		ST_OUT  = 2'd3
	} state_e_t;

	// controller to datapath
	typedef struct packed {
		logic accept;      // item taken this cycle
		logic tick_latch;  // tick that gives a latch beat
		logic rd_bot;      // top bytes back, read bottom bytes
		logic lk_bot;      // top levels back, look up bottom levels
		logic emit_shift;  // bottom levels back, send shift beat
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic shift_beat;  // column counter still inside the row
	} status_t;

endpackage

// File: hw/rtl/lmbs_ram.sv
module lmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/lmbs_ctrl.sv
module lmbs_ctrl import lmbs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   cmd,
	input  status_t      sts,
	output logic         busy,
	output ctrl_t        ctl
);

	state_e_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				ctl.accept = start;
				if (start && cmd == CMD_TICK) begin
					if (sts.shift_beat) begin
						state_d = ST_TOP;
					end else begin
						ctl.tick_latch = 1'b1;
					end
				end
			end
			ST_TOP: begin
				ctl.rd_bot = 1'b1;
				state_d    = ST_BOT;
			end
			ST_BOT: begin
				ctl.lk_bot = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				ctl.emit_shift = 1'b1;
				state_d        = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/lmbs_datapath.sv
module lmbs_datapath import lmbs_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctl,
	output status_t               sts,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [1:0]            cmd,
	input  logic                  buffer_id,
	input  logic [5:0]            pixel_x,
	input  logic [5:0]            pixel_y,
	input  logic [1:0]            channel,
	input  logic [BYTE_W-1:0]     byte_value,
	input  logic [BYTE_W-1:0]     gamma_index,
	input  logic [LEVEL_W-1:0]    gamma_level,
	output logic                  beat_valid,
	output logic                  beat_kind,
	output logic                  red_top,
	output logic                  green_top,
	output logic                  blue_top,
	output logic                  red_bottom,
	output logic                  green_bottom,
	output logic                  blue_bottom,
	output logic [ROW_ADDR_W-1:0] row_address,
	output logic [PLANE_W-1:0]    plane_index,
	output logic [LEVEL_W-1:0]    on_time,
	output logic                  frame_end
);

	localparam int PIX   = MAX_WIDTH * MAX_HEIGHT;
	localparam int DEPTH = 2 * PIX;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int YW    = ((RW > HALF_W) ? RW : HALF_W) + 1;

	function automatic logic [AW-1:0] pix_addr(input logic buf_sel, input int y, input int x);
		int a;
		a = int'(buf_sel) * PIX + y * MAX_WIDTH + x;
		return a[AW-1:0];
	endfunction

	function automatic logic plane_bit(input logic [LEVEL_W-1:0] lvl,
			input logic [PLANE_W-1:0] pl);
		logic b;
		b = 1'b0;
		if (int'(pl) < LEVEL_W) begin
			b = lvl[pl];
		end
		return b;
	endfunction

	// configuration registers
	logic [PLANE_W-1:0] plane_count_q;
	logic               active_buffer_q;
	logic [CFG_W-1:0]   panel_width_q;
	logic [CFG_W-1:0]   panel_height_q;

	// scan counters
	logic [CW-1:0]      col_q;
	logic [PLANE_W-1:0] plane_q;
	logic [RW-1:0]      row_q;
	logic               scanned_q;

	// per-beat working registers
	logic [AW-1:0]      bot_addr_q;
	logic               top_zero_q;
	logic               bot_zero_q;
	logic [NUM_CH-1:0]  top_bits_q;

	logic [BYTE_W-1:0]  frame_rdata [NUM_CH];
	logic [LEVEL_W-1:0] gamma_rdata [NUM_CH];

	logic               is_tick;
	logic               sel_buf;
	logic [YW-1:0]      y_bot;
	logic [AW-1:0]      top_addr;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               pix_ok;
	logic               gamma_we;
	logic [RW:0]        row_inc;
	logic [PLANE_W:0]   plane_inc;
	logic [HALF_W-1:0]  rows;
	logic [NUM_CH-1:0]  bot_bits;

	assign is_tick = ctl.accept && cmd == CMD_TICK;
	assign sts.shift_beat = {{(CFG_W+1){1'b0}}, col_q} < {{(CW+1){1'b0}}, panel_width_q};

	// buffer choice is sampled on the first beat of a frame
	assign sel_buf  = (row_q == '0 && plane_q == '0 && col_q == '0) ? active_buffer_q
		: scanned_q;
	assign rows     = panel_height_q[CFG_W-1:1];
	assign y_bot    = YW'(row_q) + YW'(rows);
	assign top_addr = pix_addr(sel_buf, int'(row_q), int'(col_q));
	assign raddr    = ctl.rd_bot ? bot_addr_q : top_addr;

	assign pix_ok   = ctl.accept && cmd == CMD_PIXEL && int'(channel) < NUM_CH
		&& int'(pixel_x) < MAX_WIDTH && int'(pixel_y) < MAX_HEIGHT;
	assign waddr    = pix_addr(buffer_id, int'(pixel_y), int'(pixel_x));
	assign gamma_we = ctl.accept && cmd == CMD_GAMMA;

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		lmbs_ram #(
			.WIDTH (BYTE_W),
			.DEPTH (DEPTH)
		) u_frame (
			.clk   (clk),
			.we    (pix_ok && int'(channel) == c),
			.waddr (waddr),
			.wdata (byte_value),
			.raddr (raddr),
			.rdata (frame_rdata[c])
		);

		// one gamma copy per channel, all loaded together
		lmbs_ram #(
			.WIDTH (LEVEL_W),
			.DEPTH (GAMMA_DEPTH)
		) u_gamma (
			.clk   (clk),
			.we    (gamma_we),
			.waddr (gamma_index),
			.wdata (gamma_level),
			.raddr (frame_rdata[c]),
			.rdata (gamma_rdata[c])
		);

		assign bot_bits[c] = plane_bit(gamma_rdata[c], plane_q) && !bot_zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q   <= PLANES_RST;
			active_buffer_q <= 1'b0;
			panel_width_q   <= WIDTH_RST;
			panel_height_q  <= HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (reg_e_t'(cfg_index))
				REG_PLANES: begin
					if (cfg_data[PLANE_W-1:0] != '0
						&& int'(cfg_data[PLANE_W-1:0]) <= MAX_PLANES) begin
						plane_count_q <= cfg_data[PLANE_W-1:0];
					end
				end
				REG_BUFFER: begin
					active_buffer_q <= cfg_data[0];
				end
				REG_WIDTH: begin
					if (cfg_data != '0 && int'(cfg_data) <= MAX_WIDTH) begin
						panel_width_q <= cfg_data;
					end
				end
				REG_HEIGHT: begin
					if (int'(cfg_data) >= 2 && int'(cfg_data) <= MAX_HEIGHT) begin
						panel_height_q <= cfg_data;
					end
				end
			endcase
		end
	end

	assign plane_inc = {1'b0, plane_q} + 1'b1;
	assign row_inc   = {1'b0, row_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			plane_q   <= '0;
			row_q     <= '0;
			scanned_q <= 1'b0;
		end else begin
			if (is_tick) begin
				scanned_q <= sel_buf;
			end
			if (ctl.emit_shift) begin
				col_q <= col_q + 1'b1;
			end
			if (ctl.tick_latch) begin
				col_q <= '0;
				if (plane_inc >= {1'b0, plane_count_q}) begin
					plane_q <= '0;
					if ((YW+1)'(row_inc) >= (YW+1)'(rows)) begin
						row_q <= '0;
					end else begin
						row_q <= row_inc[RW-1:0];
					end
				end else begin
					plane_q <= plane_inc[PLANE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			bot_addr_q <= pix_addr(sel_buf, int'(y_bot), int'(col_q));
			top_zero_q <= int'(col_q) >= MAX_WIDTH || int'(row_q) >= MAX_HEIGHT;
			bot_zero_q <= int'(col_q) >= MAX_WIDTH || int'(y_bot) >= MAX_HEIGHT;
		end
		if (ctl.lk_bot) begin
			for (int c = 0; c < NUM_CH; c++) begin
				top_bits_q[c] <= plane_bit(gamma_rdata[c], plane_q) && !top_zero_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid <= 1'b0;
		end else begin
			beat_valid <= ctl.tick_latch || ctl.emit_shift;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tick_latch || ctl.emit_shift) begin
			row_address <= ROW_ADDR_W'(row_q);
			plane_index <= plane_q;
			beat_kind   <= ctl.tick_latch;
		end
		if (ctl.tick_latch) begin
			{red_top, green_top, blue_top}          <= '0;
			{red_bottom, green_bottom, blue_bottom} <= '0;
			if (int'(plane_q) >= LEVEL_W) begin
				on_time <= '1;
			end else begin
				on_time <= (LEVEL_W'(1) << plane_q) - LEVEL_W'(1);
			end
			frame_end <= plane_inc >= {1'b0, plane_count_q}
				&& (YW+1)'(row_inc) >= (YW+1)'(rows);
		end
		if (ctl.emit_shift) begin
			red_top      <= top_bits_q[CH_RED];
			green_top    <= top_bits_q[CH_GREEN];
			blue_top     <= top_bits_q[CH_BLUE];
			red_bottom   <= bot_bits[CH_RED];
			green_bottom <= bot_bits[CH_GREEN];
			blue_bottom  <= bot_bits[CH_BLUE];
			on_time      <= '0;
			frame_end    <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/led_matrix_bitplane_scanner.sv
// shift beat: top read, bottom read and send states (frame ram read, gamma ram read, top then
//   bottom half through the same read ports) under busy, then the result register; a latch
//   beat is registered in the cycle after its tick and, like a store write, leaves busy low
// reset: async active low; counters and scanned buffer clear, registers take their defaults,
//   frame and gamma rams are not cleared; results cannot be stalled by the receiver
module led_matrix_bitplane_scanner import lmbs_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// item port
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic                  buffer_id,
	input  logic [5:0]            pixel_x,
	input  logic [5:0]            pixel_y,
	input  logic [1:0]            channel,
	input  logic [BYTE_W-1:0]     byte_value,
	input  logic [BYTE_W-1:0]     gamma_index,
	input  logic [LEVEL_W-1:0]    gamma_level,

	// register write port
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,

	// beat output, one strobe per beat
	output logic                  beat_valid,
	output logic                  beat_kind,
	output logic                  red_top,
	output logic                  green_top,
	output logic                  blue_top,
	output logic                  red_bottom,
	output logic                  green_bottom,
	output logic                  blue_bottom,
	output logic [ROW_ADDR_W-1:0] row_address,
	output logic [PLANE_W-1:0]    plane_index,
	output logic [LEVEL_W-1:0]    on_time,
	output logic                  frame_end
);

	ctrl_t   ctl;
	status_t sts;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: idle, top read, bottom read, send
	lmbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	// frame and gamma rams, scan counters, config and result registers
	lmbs_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.buffer_id    (buffer_id),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.channel      (channel),
		.byte_value   (byte_value),
		.gamma_index  (gamma_index),
		.gamma_level  (gamma_level),
		.beat_valid   (beat_valid),
		.beat_kind    (beat_kind),
		.red_top      (red_top),
		.green_top    (green_top),
		.blue_top     (blue_top),
		.red_bottom   (red_bottom),
		.green_bottom (green_bottom),
		.blue_bottom  (blue_bottom),
		.row_address  (row_address),
		.plane_index  (plane_index),
		.on_time      (on_time),
		.frame_end    (frame_end)
	);

endmodule
